### sv/rcc_pkg.sv
package rcc_pkg;

  // Token buffer limits
  localparam int unsigned TOKEN_MAX_CHARS = 31;
  localparam int unsigned TOKEN_BYTES     = 32;

  // Serial number limits
  localparam int unsigned SERIAL_W     = 24;
  localparam int unsigned SERIAL_LIMIT = 9999999;

  // Message bytes past this count are dropped
  localparam int unsigned MSG_CAP     = 270;
  localparam int unsigned BYTE_CNT_W  = 9;

  // First-mismatch marker meaning no mismatch seen
  localparam int unsigned NO_MISMATCH = 32;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEVICE_SERIAL     = 3'd0,
    REG_REMOTE_CUT_ENABLE = 3'd1,
    REG_TOKEN_LENGTH      = 3'd2,
    REG_TOKEN_WORD_0      = 3'd3,
    REG_TOKEN_WORD_1      = 3'd4,
    REG_TOKEN_WORD_2      = 3'd5,
    REG_TOKEN_WORD_3      = 3'd6
  } cfg_reg_t;

  // Characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_C  = 8'h43;
  localparam logic [7:0] CH_UC_T  = 8'h54;
  localparam logic [7:0] CH_UC_U  = 8'h55;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_U  = 8'h75;

endpackage

### sv/rcc_if.sv
// Message byte channel
interface rcc_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       last_byte;
  logic       prior_cut;
  logic       flight_ended;

  modport source (output valid, msg_byte, last_byte, prior_cut, flight_ended,
                  input ready);
  modport sink   (input valid, msg_byte, last_byte, prior_cut, flight_ended,
                  output ready);
endinterface

// Verdict channel
interface rcc_result_if;
  logic valid;
  logic ready;
  logic cut_accepted;
  logic ignored_after_cut;

  modport source (output valid, cut_accepted, ignored_after_cut, input ready);
  modport sink   (input valid, cut_accepted, ignored_after_cut, output ready);
endinterface

// Register write channel
interface rcc_cfg_if import rcc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/remote_cut_command_parser_top.sv
// Remote cut command parser. Takes a received message one byte per item on
// msg and checks it against "CUT,<serial>,<token>" (prefix in either case,
// serial of one or more decimal digits, leading zeros allowed, with a value
// no larger than 9999999, token of up to TOKEN_CHARS characters ending at
// NUL/CR/LF, trailing blanks trimmed). Bytes past the 270th of a message are
// dropped, but the last_byte mark still closes it. Only the item flagged
// last_byte yields a verdict item on result; all other bytes yield nothing.
// Throughput is one byte per clock: each byte is registered, then one short
// update (a x10 add with a limit compare, or one token byte compare) moves
// the parse state. The last byte is held in the input register, then its
// verdict is registered in the output register. msg stalls only when a
// verdict is held in the output register and a further last byte is
// waiting behind it. Registers must be written through cfg only while the
// parser is idle; the block itself does not enforce this. cfg never stalls.
module remote_cut_command_parser_top import rcc_pkg::*; #(
  parameter int unsigned TOKEN_CHARS = TOKEN_MAX_CHARS
) (
  input  logic        clk,
  input  logic        rst,
  rcc_msg_if.sink     msg,
  rcc_result_if.source result,
  rcc_cfg_if.sink     cfg
);

  typedef enum logic [3:0] {
    PH_C,
    PH_U,
    PH_T,
    PH_COMMA,
    PH_SERIAL_FIRST,
    PH_SERIAL,
    PH_TOKEN,
    PH_TOKEN_DONE,
    PH_REJECT
  } phase_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SERIAL_W-1:0]       device_serial;
  logic                      remote_cut_enable;
  logic [4:0]                token_length;
  logic [TOKEN_BYTES*8-1:0]  token_bytes;   // byte i at bits 8*i

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_serial     <= '0;
      remote_cut_enable <= 1'b0;
      token_length      <= '0;
      token_bytes       <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEVICE_SERIAL:     device_serial     <= cfg.data[SERIAL_W-1:0];
        REG_REMOTE_CUT_ENABLE: remote_cut_enable <= cfg.data[0];
        REG_TOKEN_LENGTH:      token_length      <= cfg.data[4:0];
        REG_TOKEN_WORD_0:      token_bytes[63:0]    <= cfg.data;
        REG_TOKEN_WORD_1:      token_bytes[127:64]  <= cfg.data;
        REG_TOKEN_WORD_2:      token_bytes[191:128] <= cfg.data;
        REG_TOKEN_WORD_3:      token_bytes[255:192] <= cfg.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       in_fired;
  logic       in_term;
  logic       in_advance;
  logic       msg_take;

  // A non-last byte never needs the output register; a last byte needs it free.
  assign in_advance = !in_last || !result.valid || result.ready;
  assign msg.ready  = !in_valid || in_advance;
  assign msg_take   = msg.valid && msg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (msg_take) begin
      in_valid <= 1'b1;
    end else if (in_advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_take) begin
      in_byte  <= msg.msg_byte;
      in_last  <= msg.last_byte;
      in_fired <= msg.prior_cut;
      in_term  <= msg.flight_ended;
    end
  end

  // ---------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------
  phase_t                phase, phase_next;
  logic [SERIAL_W-1:0]   serial_accum, serial_accum_next;
  logic [4:0]            token_count, token_count_next;
  logic [4:0]            trimmed_length, trimmed_length_next;
  logic [5:0]            first_mismatch, first_mismatch_next;
  logic [BYTE_CNT_W-1:0] byte_count, byte_count_next;

  logic        is_digit;
  logic [26:0] serial_sum;     // accum * 10 + digit, accum never above the limit
  logic [7:0]  expected_byte;
  logic [7:0]  exp_bit_idx;
  logic [4:0]  count_inc;
  logic        token_end;

  assign is_digit    = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign serial_sum  = {serial_accum, 3'b000} + {2'b00, serial_accum, 1'b0}
                     + {23'd0, in_byte[3:0]};
  assign exp_bit_idx = {token_count, 3'b000};
  assign expected_byte = token_bytes[exp_bit_idx +: 8];
  assign count_inc   = token_count + 5'd1;
  assign token_end   = (in_byte == CH_NUL) || (in_byte == CH_CR) || (in_byte == CH_LF);

  always_comb begin
    phase_next          = phase;
    serial_accum_next   = serial_accum;
    token_count_next    = token_count;
    trimmed_length_next = trimmed_length;
    first_mismatch_next = first_mismatch;
    byte_count_next     = byte_count;
    if (byte_count < BYTE_CNT_W'(MSG_CAP)) begin
      byte_count_next = byte_count + BYTE_CNT_W'(1);
      unique case (phase)
        PH_C:
          phase_next = (in_byte == CH_UC_C || in_byte == CH_LC_C) ? PH_U : PH_REJECT;
        PH_U:
          phase_next = (in_byte == CH_UC_U || in_byte == CH_LC_U) ? PH_T : PH_REJECT;
        PH_T:
          phase_next = (in_byte == CH_UC_T || in_byte == CH_LC_T) ? PH_COMMA : PH_REJECT;
        PH_COMMA:
          phase_next = (in_byte == CH_COMMA) ? PH_SERIAL_FIRST : PH_REJECT;
        PH_SERIAL_FIRST, PH_SERIAL: begin
          if (is_digit) begin
            if (serial_sum > 27'(SERIAL_LIMIT)) begin
              phase_next = PH_REJECT;
            end else begin
              serial_accum_next = serial_sum[SERIAL_W-1:0];
              phase_next        = PH_SERIAL;
            end
          end else if (in_byte == CH_COMMA && phase == PH_SERIAL) begin
            phase_next = PH_TOKEN;
          end else begin
            phase_next = PH_REJECT;
          end
        end
        PH_TOKEN: begin
          if (token_end || token_count >= 5'(TOKEN_CHARS)) begin
            phase_next = PH_TOKEN_DONE;
          end else begin
            if (first_mismatch == 6'(NO_MISMATCH) && in_byte != expected_byte) begin
              first_mismatch_next = {1'b0, token_count};
            end
            token_count_next = count_inc;
            if (in_byte != CH_SPACE && in_byte != CH_TAB) begin
              trimmed_length_next = count_inc;
            end
            if (count_inc >= 5'(TOKEN_CHARS)) begin
              phase_next = PH_TOKEN_DONE;
            end
          end
        end
        default: ;  // token done or rejected: byte has no effect
      endcase
    end
  end

  logic step;
  assign step = in_valid && in_advance;

  // ---------------------------------------------------------------------
  // Verdict, from the state after the last byte
  // ---------------------------------------------------------------------
  logic cmd_ok;
  logic ignore;

  assign cmd_ok = (phase_next == PH_TOKEN || phase_next == PH_TOKEN_DONE)
               && serial_accum_next == device_serial
               && remote_cut_enable
               && trimmed_length_next == token_length
               && first_mismatch_next >= {1'b0, trimmed_length_next};
  assign ignore = in_fired || in_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_C;
      serial_accum   <= '0;
      token_count    <= '0;
      trimmed_length <= '0;
      first_mismatch <= 6'(NO_MISMATCH);
      byte_count     <= '0;
      result.valid   <= 1'b0;
    end else if (step && in_last) begin
      // message closed: verdict out, parser back to its start
      phase                    <= PH_C;
      serial_accum             <= '0;
      token_count              <= '0;
      trimmed_length           <= '0;
      first_mismatch           <= 6'(NO_MISMATCH);
      byte_count               <= '0;
      result.valid             <= 1'b1;
      result.cut_accepted      <= cmd_ok && !ignore;
      result.ignored_after_cut <= ignore;
    end else begin
      if (step) begin
        phase          <= phase_next;
        serial_accum   <= serial_accum_next;
        token_count    <= token_count_next;
        trimmed_length <= trimmed_length_next;
        first_mismatch <= first_mismatch_next;
        byte_count     <= byte_count_next;
      end
      if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule

### sv/rcc_checker.sv
module rcc_checker (
  input logic clk,
  input logic rst,
  input logic msg_valid,
  input logic msg_ready,
  input logic msg_last,
  input logic res_valid,
  input logic res_ready,
  input logic res_accepted,
  input logic res_ignored
);

  logic msg_take_last;
  assign msg_take_last = msg_valid && msg_ready && msg_last;

  // A held verdict keeps its value
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_accepted) && $stable(res_ignored))
    else $error("verdict changed while stalled");

  // An ignored message is never accepted
  a_ignored_not_accepted: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_ignored && res_accepted))
    else $error("verdict both ignored and accepted");

  // A fresh verdict comes from a taken last byte
  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(msg_take_last, 2))
    else $error("verdict without a last byte");

  // Second last byte behind a stalled verdict blocks further input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    msg_take_last && res_valid && !res_ready |=> !(res_valid && !res_ready) || !msg_ready)
    else $error("input not held back behind stalled verdict");

endmodule

bind remote_cut_command_parser_top rcc_checker u_rcc_checker (
  .clk          (clk),
  .rst          (rst),
  .msg_valid    (msg.valid),
  .msg_ready    (msg.ready),
  .msg_last     (msg.last_byte),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_accepted (result.cut_accepted),
  .res_ignored  (result.ignored_after_cut)
);

### bench/testbench.sv
package cut_check_pkg;
  import rcc_pkg::*;

  // Parser position, mirrors the block's progress through "CUT,<serial>,<token>"
  typedef enum logic [3:0] {
    WANT_C,
    WANT_U,
    WANT_T,
    WANT_COMMA,
    SERIAL_FIRST,
    SERIAL_MORE,
    IN_TOKEN,
    TOKEN_DONE,
    REJECTED
  } parse_phase_t;

  typedef struct packed {
    logic accepted;
    logic ignored;
  } verdict_t;

  class verdict_scoreboard;
    // register shadow
    logic [SERIAL_W-1:0] dev_serial;
    logic                cut_enable;
    logic [4:0]          tok_len;
    logic [63:0]         tok_word [4];

    // parse state
    parse_phase_t phase;
    int unsigned  serial_val;
    int unsigned  tok_count;
    int unsigned  trim_len;
    int unsigned  mismatch_at;
    int unsigned  msg_bytes;

    verdict_t    verdicts_due [$];
    int unsigned n_err;
    int unsigned n_bytes;
    int unsigned n_verdicts;
    int unsigned n_accepted;
    int unsigned n_ignored;

    function new();
      dev_serial = '0;
      cut_enable = 1'b0;
      tok_len    = '0;
      foreach (tok_word[i]) tok_word[i] = '0;
      n_err      = 0;
      n_bytes    = 0;
      n_verdicts = 0;
      n_accepted = 0;
      n_ignored  = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase       = WANT_C;
      serial_val  = 0;
      tok_count   = 0;
      trim_len    = 0;
      mismatch_at = NO_MISMATCH;
      msg_bytes   = 0;
    endfunction

    function logic [7:0] tok_byte(int unsigned idx);
      return tok_word[(idx >> 3) & 3][(idx & 7) * 8 +: 8];
    endfunction

    function void set_reg(cfg_reg_t idx, logic [63:0] val);
      case (idx)
        REG_DEVICE_SERIAL:     dev_serial = val[SERIAL_W-1:0];
        REG_REMOTE_CUT_ENABLE: cut_enable = val[0];
        REG_TOKEN_LENGTH:      tok_len = val[4:0];
        REG_TOKEN_WORD_0:      tok_word[0] = val;
        REG_TOKEN_WORD_1:      tok_word[1] = val;
        REG_TOKEN_WORD_2:      tok_word[2] = val;
        REG_TOKEN_WORD_3:      tok_word[3] = val;
        default: ;
      endcase
    endfunction

    function void take_token(logic [7:0] c);
      if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
        phase = TOKEN_DONE;
        return;
      end
      if (tok_count >= TOKEN_MAX_CHARS) begin
        phase = TOKEN_DONE;
        return;
      end
      if (mismatch_at == NO_MISMATCH && c != tok_byte(tok_count)) mismatch_at = tok_count;
      tok_count++;
      if (c != CH_SPACE && c != CH_TAB) trim_len = tok_count;
      if (tok_count >= TOKEN_MAX_CHARS) phase = TOKEN_DONE;
    endfunction

    function void advance(logic [7:0] c);
      int unsigned nxt;
      case (phase)
        WANT_C:     phase = (c == CH_UC_C || c == CH_LC_C) ? WANT_U : REJECTED;
        WANT_U:     phase = (c == CH_UC_U || c == CH_LC_U) ? WANT_T : REJECTED;
        WANT_T:     phase = (c == CH_UC_T || c == CH_LC_T) ? WANT_COMMA : REJECTED;
        WANT_COMMA: phase = (c == CH_COMMA) ? SERIAL_FIRST : REJECTED;
        SERIAL_FIRST, SERIAL_MORE: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            nxt = serial_val * 10 + int'(c - CH_ZERO);
            if (nxt > SERIAL_LIMIT) begin
              phase = REJECTED;
            end else begin
              serial_val = nxt;
              phase = SERIAL_MORE;
            end
          end else if (c == CH_COMMA && phase == SERIAL_MORE) begin
            phase = IN_TOKEN;
          end else begin
            phase = REJECTED;
          end
        end
        IN_TOKEN: take_token(c);
        default: ;
      endcase
    endfunction

    // One accepted message byte; a verdict is due only on the last one
    function void note_byte(logic [7:0] c, logic is_last, logic fired, logic term);
      verdict_t v;
      n_bytes++;
      if (msg_bytes < MSG_CAP) begin
        msg_bytes++;
        advance(c);
      end
      if (!is_last) return;
      if (fired || term) begin
        v.accepted = 1'b0;
        v.ignored  = 1'b1;
      end else begin
        v.ignored  = 1'b0;
        v.accepted = (phase == IN_TOKEN || phase == TOKEN_DONE) && serial_val == dev_serial
                     && cut_enable && trim_len == tok_len && mismatch_at >= trim_len;
      end
      verdicts_due.push_back(v);
      clear_parse();
    endfunction

    task report(string what);
      n_err++;
      if (n_err <= 100) $display("ERROR: %s", what);
    endtask

    task check_verdict(logic acc, logic ign);
      verdict_t due;
      if (verdicts_due.size() == 0) begin
        report($sformatf("verdict with no message pending: accepted=%b ignored=%b", acc, ign));
        return;
      end
      due = verdicts_due.pop_front();
      n_verdicts++;
      if (due.accepted) n_accepted++;
      if (due.ignored) n_ignored++;
      if (acc !== due.accepted)
        report($sformatf("verdict %0d: cut_accepted=%b, predicted %b",
                         n_verdicts, acc, due.accepted));
      if (ign !== due.ignored)
        report($sformatf("verdict %0d: ignored_after_cut=%b, predicted %b",
                         n_verdicts, ign, due.ignored));
    endtask
  endclass

endpackage

module testbench;
  import rcc_pkg::*;
  import cut_check_pkg::*;

  // Per-item wait styles for either side of the block
  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_FULL,
    IDLE_SPARSE
  } idle_mode_t;

  // Ways of spoiling a well-formed command
  typedef enum int unsigned {
    DAMAGE_SHORT,
    DAMAGE_CORRUPT,
    DAMAGE_NUL
  } damage_t;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned PHASE_BYTES   = 20;    // minimum random bytes per register setting
  localparam int unsigned HOLD_MSGS     = 4;     // minimum messages offered in the hold-off phase
  localparam int unsigned SETTLE_CYCLES = 8;     // settle time after the last verdict
  localparam logic [7:0]  TOKEN_ENDS [3] = '{CH_NUL, CH_CR, CH_LF};

  logic clk = 1'b0;
  logic rst;

  rcc_msg_if    msg_ch ();
  rcc_result_if res_ch ();
  rcc_cfg_if    cfg_ch ();

  remote_cut_command_parser_top u_top (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  verdict_scoreboard sb = new();

  logic [7:0]  msg_buf [$];     // message being assembled
  logic [7:0]  tok_chars [32];  // token for the next register setting
  idle_mode_t  src_mode  = IDLE_SPARSE;
  idle_mode_t  sink_mode = IDLE_SPARSE;
  bit          hold_req  = 1'b0;
  int unsigned cycles    = 0;
  int unsigned settings_used = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycles, sb.verdicts_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 15);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  // Any byte that does not close a token
  function automatic logic [7:0] token_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  //--------------------------------------------------------------------------
  // Message assembly
  //--------------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] c);
    msg_buf.push_back(c);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
  endfunction

  // "CUT," with each letter in a random case
  function automatic void put_prefix();
    put_byte($urandom_range(0, 1) ? CH_UC_C : CH_LC_C);
    put_byte($urandom_range(0, 1) ? CH_UC_U : CH_LC_U);
    put_byte($urandom_range(0, 1) ? CH_UC_T : CH_LC_T);
    put_byte(CH_COMMA);
  endfunction

  function automatic void put_serial(int unsigned value, int unsigned zeros);
    repeat (zeros) put_byte(CH_ZERO);
    put_str($sformatf("%0d", value));
  endfunction

  // First n bytes of the token the block holds now
  function automatic void put_expected(int unsigned n);
    for (int unsigned i = 0; i < n; i++) put_byte(sb.tok_byte(i));
  endfunction

  function automatic int unsigned pick_serial();
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, 99);
      1:       return $urandom_range(100, 99999);
      default: return $urandom_range(0, SERIAL_LIMIT);
    endcase
  endfunction

  // Mostly a valid command for the current setting, with random slips
  function automatic void build_command();
    int unsigned sel;
    int unsigned tl;
    tl = sb.tok_len;
    put_prefix();
    sel = $urandom_range(0, 99);
    if (sel < 70)      put_serial(sb.dev_serial, 0);
    else if (sel < 80) put_serial(sb.dev_serial, $urandom_range(1, 3));
    else if (sel < 88) put_serial(pick_serial(), 0);
    else if (sel < 94) put_serial($urandom_range(SERIAL_LIMIT + 1, 99999999), 0);
    else               put_serial(sb.dev_serial ^ 1, 0);
    put_byte(CH_COMMA);

    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      put_expected(tl);
    end else if (sel < 78 && tl != 0) begin
      put_expected(tl);
      msg_buf[msg_buf.size() - 1 - $urandom_range(0, tl - 1)] = token_char();
    end else if (sel < 88) begin
      put_expected($urandom_range(0, tl));
    end else begin
      repeat ($urandom_range(0, 40)) put_byte(token_char());
    end

    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      repeat ($urandom_range(1, 3)) put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end else if (sel < 50) begin
      put_byte(TOKEN_ENDS[$urandom_range(0, 2)]);
      repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void damage_command();
    int unsigned keep;
    case (damage_t'($urandom_range(0, 2)))
      DAMAGE_SHORT: begin
        keep = $urandom_range(1, msg_buf.size() - 1);
        while (msg_buf.size() > keep) void'(msg_buf.pop_back());
      end
      DAMAGE_CORRUPT: msg_buf[$urandom_range(0, msg_buf.size() - 1)] = 8'($urandom_range(0, 255));
      default:        msg_buf.insert($urandom_range(0, 5), CH_NUL);
    endcase
  endfunction

  //--------------------------------------------------------------------------
  // Drivers: inputs move on the falling edge, handshakes sampled on the rising
  //--------------------------------------------------------------------------
  task automatic send_item(logic [7:0] c, logic is_last, logic fired, logic term);
    int unsigned gap;
    gap = draw_wait(src_mode);
    @(negedge clk);
    if (gap != 0) begin
      msg_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_ch.valid        = 1'b1;
    msg_ch.msg_byte     = c;
    msg_ch.last_byte    = is_last;
    msg_ch.prior_cut    = fired;
    msg_ch.flight_ended = term;
    do @(posedge clk); while (msg_ch.ready !== 1'b1);
    sb.note_byte(c, is_last, fired, term);
  endtask

  // Flags only count on the last byte; elsewhere they toggle freely
  task automatic send_msg(bit fired, bit term);
    int unsigned n;
    bit is_last;
    n = msg_buf.size();
    for (int unsigned i = 0; i < n; i++) begin
      is_last = (i == n - 1);
      send_item(msg_buf[i], is_last,
                is_last ? fired : 1'($urandom_range(0, 1)),
                is_last ? term  : 1'($urandom_range(0, 1)));
    end
    msg_buf.delete();
  endtask

  // Stop offering bytes and let every pending verdict come out
  task automatic wait_drained();
    @(negedge clk);
    msg_ch.valid = 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Full register setting, taken from tok_chars for the token
  task automatic load_setting(int unsigned serial, bit enable, int unsigned len);
    logic [63:0] words [4];
    wait_drained();
    for (int w = 0; w < 4; w++)
      for (int b = 0; b < 8; b++) words[w][b*8 +: 8] = tok_chars[w*8 + b];
    write_reg(REG_DEVICE_SERIAL, 64'(serial));
    write_reg(REG_REMOTE_CUT_ENABLE, 64'(enable));
    write_reg(REG_TOKEN_LENGTH, 64'(len));
    write_reg(REG_TOKEN_WORD_0, words[0]);
    write_reg(REG_TOKEN_WORD_1, words[1]);
    write_reg(REG_TOKEN_WORD_2, words[2]);
    write_reg(REG_TOKEN_WORD_3, words[3]);
    settings_used++;
  endtask

  // Printable last char so the expected token survives trimming
  function automatic void make_token(int unsigned len, bit with_nul);
    for (int unsigned i = 0; i < 32; i++)
      tok_chars[i] = (i < len) ? token_char() : 8'($urandom_range(0, 255));
    if (len != 0) tok_chars[len - 1] = 8'($urandom_range(8'h21, 8'h7e));
    if (with_nul && len != 0) tok_chars[$urandom_range(0, len - 1)] = CH_NUL;
  endfunction

  function automatic void set_token_str(string s);
    for (int i = 0; i < 32; i++)
      tok_chars[i] = (i < s.len()) ? s[i] : 8'($urandom_range(0, 255));
  endfunction

  //--------------------------------------------------------------------------
  // Directed messages
  //--------------------------------------------------------------------------
  task automatic directed_part();
    src_mode  = IDLE_SPARSE;
    sink_mode = IDLE_SPARSE;
    set_token_str("Secret-42");
    load_setting(1234567, 1'b1, 9);

    // good commands: plain, mixed case, trailing blanks, leading zeros + CR, NUL or LF end
    put_str("CUT,1234567,Secret-42"); send_msg(0, 0);
    put_str("cUt,1234567,Secret-42"); put_byte(CH_SPACE); put_byte(CH_TAB); send_msg(0, 0);
    put_str("CuT,0001234567,Secret-42"); put_byte(CH_CR); put_str("junk"); send_msg(0, 0);
    put_str("CUT,1234567,Secret-42"); put_byte(CH_NUL); put_str("zz"); send_msg(0, 0);
    put_str("CUT,1234567,Secret-42"); put_byte(CH_LF); send_msg(0, 0);

    // already cut / flight over: ignored whatever the text
    put_str("CUT,1234567,Secret-42"); send_msg(1, 0);
    put_str("CUT,1234567,Secret-42"); send_msg(0, 1);
    put_str("garbage"); send_msg(1, 1);

    // serial problems
    put_str("CUT,12345678,Secret-42"); send_msg(0, 0);
    put_str("CUT,,Secret-42"); send_msg(0, 0);
    put_str("CUT,123a4567,Secret-42"); send_msg(0, 0);
    put_str("CUT,1234566,Secret-42"); send_msg(0, 0);
    put_str("CUT,1234567"); send_msg(0, 0);

    // NUL ahead of the token
    put_str("CU"); put_byte(CH_NUL); put_str("T,1234567,Secret-42"); send_msg(0, 0);
    put_str("CUT,123"); put_byte(CH_NUL); put_str("4567,Secret-42"); send_msg(0, 0);

    // prefix problems, one-byte message
    put_str("XUT,1234567,Secret-42"); send_msg(0, 0);
    put_str("CUT;1234567,Secret-42"); send_msg(0, 0);
    put_str("C"); send_msg(0, 0);

    // token problems: short, long, wrong char
    put_str("CUT,1234567,Secret"); send_msg(0, 0);
    put_str("CUT,1234567,Secret-42X"); send_msg(0, 0);
    put_str("CUT,1234567,Secret-43"); send_msg(0, 0);

    // 270 bytes exactly fits; one more drops the last token char
    put_str("CUT,"); repeat (249) put_byte(CH_ZERO); put_str("1234567,Secret-42");
    send_msg(0, 0);
    put_str("CUT,"); repeat (250) put_byte(CH_ZERO); put_str("1234567,Secret-42");
    send_msg(0, 0);

    // max serial, full 31-char token with bytes after it
    make_token(31, 1'b0);
    load_setting(SERIAL_LIMIT, 1'b1, 31);
    put_prefix(); put_serial(SERIAL_LIMIT, 0); put_byte(CH_COMMA); put_expected(31);
    put_str("extra"); send_msg(0, 0);

    // empty token, blank-only token, one-char token
    make_token(0, 1'b0);
    load_setting(0, 1'b1, 0);
    put_str("CUT,0,"); send_msg(0, 0);
    put_str("cut,00, "); put_byte(CH_TAB); send_msg(0, 0);
    put_str("CUT,0,x"); send_msg(0, 0);

    // remote cut disabled
    load_setting(0, 1'b0, 0);
    put_str("CUT,0,"); send_msg(0, 0);

    // expected token holding a NUL can never match
    set_token_str("abzd");
    tok_chars[2] = CH_NUL;
    load_setting(0, 1'b1, 4);
    put_str("CUT,0,ab"); send_msg(0, 0);
    put_str("CUT,0,abd"); send_msg(0, 0);
  endtask

  //--------------------------------------------------------------------------
  // Random messages under one register setting
  //--------------------------------------------------------------------------
  task automatic random_message();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      build_command();
    end else if (sel < 78) begin
      build_command();
      damage_command();
    end else if (sel < 98) begin
      if ($urandom_range(0, 1)) put_prefix();
      repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      // padded serial pushing the command up to or across the byte cap
      put_prefix();
      repeat ($urandom_range(230, 265)) put_byte(CH_ZERO);
      put_serial(sb.dev_serial, 0);
      put_byte(CH_COMMA);
      put_expected(sb.tok_len);
    end
    send_msg($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
  endtask

  // With a hold-off, enough messages go out that a later last byte
  // piles up behind the held verdict
  task automatic random_phase(int unsigned serial, bit enable, int unsigned len, bit with_nul,
                              idle_mode_t src, idle_mode_t snk, bit hold, bit pause);
    int unsigned start;
    int unsigned n_msgs;
    bit paused;
    paused = 1'b0;
    n_msgs = 0;
    make_token(len, with_nul);
    load_setting(serial, enable, len);
    src_mode  = src;
    sink_mode = snk;
    hold_req  = hold;
    start = sb.n_bytes;
    while (sb.n_bytes - start < PHASE_BYTES || (hold && n_msgs < HOLD_MSGS)) begin
      random_message();
      n_msgs++;
      if (pause && !paused && sb.n_bytes - start >= PHASE_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  //--------------------------------------------------------------------------
  // Verdict side: random stalls, one long hold-off on request
  //--------------------------------------------------------------------------
  initial begin : verdict_sink
    int unsigned stall;
    res_ch.ready = 1'b0;
    forever begin
      stall = draw_wait(sink_mode);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      @(negedge clk);
      if (stall != 0) begin
        res_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      sb.check_verdict(res_ch.cut_accepted, res_ch.ignored_after_cut);
    end
  end

  //--------------------------------------------------------------------------
  // Main sequence
  //--------------------------------------------------------------------------
  initial begin : stimulus
    rst                 = 1'b1;
    msg_ch.valid        = 1'b0;
    msg_ch.msg_byte     = '0;
    msg_ch.last_byte    = 1'b0;
    msg_ch.prior_cut    = 1'b0;
    msg_ch.flight_ended = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_DEVICE_SERIAL;
    cfg_ch.data         = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_part();

    // register extremes, a disabled phase, a NUL token, a hold-off, a drain pause
    random_phase(SERIAL_LIMIT, 1'b1, 31, 1'b0, IDLE_FULL, IDLE_FULL, 1'b0, 1'b0);
    random_phase(0, 1'b1, 0, 1'b0, IDLE_SPARSE, IDLE_FULL, 1'b0, 1'b0);
    random_phase(pick_serial(), 1'b1, $urandom_range(1, 30), 1'b0,
                 IDLE_NONE, IDLE_SPARSE, 1'b1, 1'b0);
    random_phase(pick_serial(), 1'b0, $urandom_range(0, 31), 1'b0,
                 IDLE_FULL, IDLE_NONE, 1'b0, 1'b0);
    random_phase(pick_serial(), 1'b1, $urandom_range(2, 31), 1'b1,
                 IDLE_SPARSE, IDLE_SPARSE, 1'b0, 1'b0);
    random_phase(pick_serial(), 1'b1, $urandom_range(0, 31), 1'b0,
                 IDLE_NONE, IDLE_NONE, 1'b0, 1'b1);

    wait_drained();

    $display("run covered %0d message bytes and %0d verdicts (%0d accepted, %0d ignored)",
             sb.n_bytes, sb.n_verdicts, sb.n_accepted, sb.n_ignored);
    $display("across %0d register settings with %0d mismatches", settings_used, sb.n_err);
    if (sb.n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
